/* src/wphf_pkg.sv */
`default_nettype none
package wphf_pkg;
    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_COMMIT  = 3'd1;
    localparam logic [2:0] REQ_START   = 3'd2;
    localparam logic [2:0] REQ_STOP    = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;
    localparam logic [2:0] REQ_RELEASE = 3'd5;
    localparam logic [2:0] REQ_ENCODER = 3'd6;

    localparam int HEAD_LIMIT = 23040;
    localparam int MAX_POINTS = 64;

    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] r;
        begin
            unique case (i)
                5'd0: r = 22'd2949120;
                5'd1: r = 22'd1740967;
                5'd2: r = 22'd919879;
                5'd3: r = 22'd466945;
                5'd4: r = 22'd234379;
                5'd5: r = 22'd117304;
                5'd6: r = 22'd58666;
                5'd7: r = 22'd29335;
                5'd8: r = 22'd14668;
                5'd9: r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* src/wphf_cordic.sv */
`default_nettype none
module wphf_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [16:0] ex,
    input  wire logic signed [16:0] ny,
    output logic                    done,
    output logic signed [15:0]      heading
);
    localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int CW = $clog2(STEPS + 1);
    localparam logic signed [31:0] HEAD_LIM = 32'(wphf_pkg::HEAD_LIMIT);

    logic busy_reg, busy_next;
    logic [CW-1:0] step_reg, step_next;
    logic signed [39:0] x_reg, x_next, y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic done_reg, done_next;
    logic signed [15:0] head_reg, head_next;

    logic signed [39:0] xs, ys, x0, y0;
    logic signed [31:0] zr, za, zq;

    always_comb
    begin
        x0 = 40'(ny) <<< 20;
        y0 = 40'(ex) <<< 20;
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        done_next = 1'b0;
        head_next = head_reg;
        za = (z_reg >= 0) ? z_reg : -z_reg;
        zq = (za + 32'sd256) >>> 9;
        zr = (z_reg >= 0) ? zq : -zq;
        if (zr > HEAD_LIM) zr = HEAD_LIM;
        if (zr < -HEAD_LIM) zr = -HEAD_LIM;
        if (start)
        begin
            if (ex == 0 && ny == 0)
            begin
                done_next = 1'b1;
                head_next = '0;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = '0;
                if (x0 < 0 && y0 >= 0)
                begin
                    x_next = y0; y_next = -x0; z_next = 32'sd5898240;
                end
                else if (x0 < 0)
                begin
                    x_next = -y0; y_next = x0; z_next = -32'sd5898240;
                end
                else
                begin
                    x_next = x0; y_next = y0; z_next = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (32'(step_reg) == STEPS)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                head_next = zr[15:0];
            end
            else
            begin
                step_next = step_reg + 1'b1;
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys; y_next = y_reg - xs;
                    z_next = z_reg + 32'(wphf_pkg::atan_entry(5'(step_reg)));
                end
                else
                begin
                    x_next = x_reg - ys; y_next = y_reg + xs;
                    z_next = z_reg - 32'(wphf_pkg::atan_entry(5'(step_reg)));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        head_reg <= head_next;
    end

    assign done = done_reg;
    assign heading = head_reg;
endmodule
`default_nettype wire

/* src/waypoint_path_heading_follower_top.sv */
`default_nettype none
// Waypoint path heading follower.
// One request channel (valid/ready) carries point writes, commit, start, stop,
// clear, latch release and encoder ticks; every request gives exactly one
// result on the result channel (valid/ready), holding the heading, run flag,
// stop latch and current segment.
// A simple request passes through S_OUT into the output register. A commit walks
// the points one segment at a time through a bit-serial square root and a
// multiply. An encoder tick on a running path with a changed delta walks the
// length memory once for the total and, unless the end is reached, again to
// the current segment, one entry a cycle, and then runs the CORDIC. The point
// and length memories are read one entry per cycle through registered ports.
// One request is in work at a time; a new request is taken only when the
// output register is empty or being read in the same cycle. If the receiver
// stalls, the result is held and no further request is taken.
// After reset the length table reads as zero through the fill count, the
// count of points in use is zero, and pulses_per_grid is 100.
module waypoint_path_heading_follower_top #(
    parameter int LENGTH_FRAC_BITS = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         req_type,
    input  wire logic [5:0]         point_index,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic [6:0]         path_count,
    input  wire logic signed [15:0] encoder_delta,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      target_heading,
    output logic                    is_running,
    output logic                    stop_latched,
    output logic [5:0]              current_segment
);
    localparam int MAX_POINTS = wphf_pkg::MAX_POINTS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int F = LENGTH_FRAC_BITS;
    localparam int QW = 18 + F;
    localparam int RW = QW + 2;
    localparam logic [39:0] LEN_MAX = '1;
    localparam logic signed [47:0] MILE_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] MILE_MIN = {1'b1, {47{1'b0}}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CRD    = 4'd1;
    localparam logic [3:0] S_CPA    = 4'd2;
    localparam logic [3:0] S_CROOT  = 4'd3;
    localparam logic [3:0] S_CMUL   = 4'd4;
    localparam logic [3:0] S_TOT    = 4'd5;
    localparam logic [3:0] S_TCMP   = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_PRD    = 4'd8;
    localparam logic [3:0] S_PA     = 4'd9;
    localparam logic [3:0] S_PB     = 4'd10;
    localparam logic [3:0] S_CWAIT  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;
    localparam logic [3:0] S_CSQ    = 4'd13;

    logic signed [15:0] xmem [MAX_POINTS];
    logic signed [15:0] ymem [MAX_POINTS];
    logic [39:0] lmem [MAX_POINTS];

    logic [3:0] st_reg, st_next;
    logic [15:0] ppg_reg;
    logic [NW-1:0] nuse_reg, nuse_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic run_reg, run_next, latch_reg, latch_next;
    logic signed [47:0] mile_reg, mile_next;
    logic [15:0] prev_reg, prev_next;
    logic signed [15:0] head_reg, head_next;
    logic [5:0] seg_reg, seg_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic signed [15:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [35:0] d2_reg, d2_next;
    logic [QW-1:0] q_reg, q_next;
    logic [RW-1:0] r_reg, r_next;
    logic [5:0] k_reg, k_next;
    logic [47:0] acc_reg, acc_next;
    logic [47:0] tot_reg, tot_next;
    logic ovalid_reg, ovalid_next;
    logic signed [15:0] oh_reg, oh_next;
    logic orun_reg, orun_next, olat_reg, olat_next;
    logic [5:0] oseg_reg, oseg_next;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next;

    logic signed [15:0] xrd_reg, yrd_reg;
    logic [39:0] lrd_reg;
    logic [AW-1:0] raddr;
    logic lwe;
    logic [AW-1:0] lwaddr;
    logic [39:0] lwdata;
    logic [39:0] lval;
    logic crd_start, crd_done;
    logic signed [15:0] crd_head;

    logic [57:0] prod;
    logic [RW-1:0] rsh, tq;
    logic [1:0] pair;
    logic [47:0] cpa;
    logic signed [48:0] msum;
    logic signed [33:0] sqx, sqy;

    assign in_ready = (st_reg == S_IDLE) && (!ovalid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && req_type == wphf_pkg::REQ_WRITE
            && 32'(point_index) < MAX_POINTS)
        begin
            xmem[AW'(point_index)] <= point_x;
            ymem[AW'(point_index)] <= point_y;
        end
        if (lwe)
            lmem[lwaddr] <= lwdata;
        xrd_reg <= xmem[raddr];
        yrd_reg <= ymem[raddr];
        lrd_reg <= lmem[raddr];
    end

    assign lval = (32'(idx_reg) - 1 < 32'(fill_reg)) ? lrd_reg : 40'd0;

    wphf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(crd_start),
        .ex(dx_reg), .ny(dy_reg), .done(crd_done), .heading(crd_head)
    );

    always_comb
    begin
        st_next = st_reg;
        nuse_next = nuse_reg;
        fill_next = fill_reg;
        run_next = run_reg;
        latch_next = latch_reg;
        mile_next = mile_reg;
        prev_next = prev_reg;
        head_next = head_reg;
        seg_next = seg_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        d2_next = d2_reg;
        q_next = q_reg;
        r_next = r_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        tot_next = tot_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        ovalid_next = ovalid_reg && !out_ready;
        oh_next = oh_reg;
        orun_next = orun_reg;
        olat_next = olat_reg;
        oseg_next = oseg_reg;
        raddr = AW'(idx_reg);
        lwe = 1'b0;
        lwaddr = AW'(idx_reg);
        lwdata = '0;
        crd_start = 1'b0;
        pair = (k_reg < 6'd18) ? 2'(d2_reg >> (2 * (17 - 32'(k_reg)))) : 2'd0;
        rsh = {r_reg[RW-3:0], pair};
        tq = {q_reg[QW-1:0], 2'b01};
        prod = 58'(q_reg) * 58'(ppg_reg);
        cpa = (acc_reg + 48'(lval) + 48'((1 << F) - 1)) >> F;
        msum = 49'(mile_reg) + 49'(encoder_delta);
        sqx = 34'(dx_reg) * 34'(dx_reg);
        sqy = 34'(dy_reg) * 34'(dy_reg);
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    st_next = S_OUT;
                    unique case (req_type)
                        wphf_pkg::REQ_COMMIT:
                        begin
                            nuse_next = (path_count > 7'(MAX_POINTS))
                                ? NW'(MAX_POINTS) : NW'(path_count);
                            fill_next = '0;
                            idx_next = NW'(1);
                            raddr = '0;
                            st_next = S_CRD;
                        end
                        wphf_pkg::REQ_START:
                            if (nuse_reg >= NW'(2))
                            begin
                                run_next = 1'b1;
                                mile_next = '0;
                            end
                        wphf_pkg::REQ_STOP: run_next = 1'b0;
                        wphf_pkg::REQ_CLEAR:
                        begin
                            nuse_next = '0;
                            fill_next = '0;
                            run_next = 1'b0;
                            mile_next = '0;
                        end
                        wphf_pkg::REQ_RELEASE: latch_next = 1'b0;
                        wphf_pkg::REQ_ENCODER:
                        begin
                            if (!run_reg || nuse_reg < NW'(2))
                            begin
                                head_next = '0;
                                seg_next = '0;
                                prev_next = '0;
                            end
                            else if (encoder_delta != prev_reg)
                            begin
                                prev_next = encoder_delta;
                                if (msum > 49'(MILE_MAX)) mile_next = MILE_MAX;
                                else if (msum < 49'(MILE_MIN)) mile_next = MILE_MIN;
                                else mile_next = 48'(msum);
                                idx_next = NW'(1);
                                raddr = AW'(1);
                                acc_next = '0;
                                st_next = S_TOT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CRD:
            begin
                if (idx_reg >= nuse_reg)
                    st_next = S_OUT;
                else
                begin
                    ax_next = xrd_reg;
                    ay_next = yrd_reg;
                    raddr = AW'(idx_reg);
                    st_next = S_CPA;
                end
            end
            S_CPA:
            begin
                dx_next = 17'(xrd_reg) - 17'(ax_reg);
                dy_next = 17'(yrd_reg) - 17'(ay_reg);
                ax_next = xrd_reg;
                ay_next = yrd_reg;
                st_next = S_CSQ;
            end
            S_CSQ:
            begin
                d2_next = 36'(sqx) + 36'(sqy);
                q_next = '0;
                r_next = '0;
                k_next = '0;
                st_next = S_CROOT;
            end
            S_CROOT:
            begin
                if (32'(k_reg) == QW)
                    st_next = S_CMUL;
                else
                begin
                    k_next = k_reg + 1'b1;
                    if (rsh >= tq)
                    begin
                        r_next = rsh - tq;
                        q_next = {q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next = rsh;
                        q_next = {q_reg[QW-2:0], 1'b0};
                    end
                end
            end
            S_CMUL:
            begin
                lwe = 1'b1;
                lwaddr = AW'(idx_reg);
                lwdata = (prod > 58'(LEN_MAX)) ? LEN_MAX : 40'(prod);
                fill_next = idx_reg;
                if (idx_reg + 1'b1 >= nuse_reg)
                    st_next = S_OUT;
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr = AW'(idx_reg + 1'b1);
                    st_next = S_CPA;
                end
            end
            S_TOT:
            begin
                acc_next = acc_reg + 48'(lval);
                if (idx_reg + 1'b1 >= nuse_reg)
                    st_next = S_TCMP;
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr = AW'(idx_reg + 1'b1);
                end
            end
            S_TCMP:
            begin
                tot_next = (acc_reg + 48'((1 << F) - 1)) >> F;
                if (mile_reg >= 0 && 48'(mile_reg) >= tot_next)
                begin
                    run_next = 1'b0;
                    head_next = '0;
                    seg_next = '0;
                    latch_next = 1'b1;
                    st_next = S_OUT;
                end
                else
                begin
                    acc_next = '0;
                    idx_next = NW'(1);
                    raddr = AW'(1);
                    st_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if ((mile_reg < 0) || (48'(mile_reg) < cpa)
                    || (idx_reg + 1'b1 >= nuse_reg))
                begin
                    cnt_next = idx_reg;
                    raddr = AW'(idx_reg - 1'b1);
                    st_next = S_PRD;
                end
                else
                begin
                    acc_next = acc_reg + 48'(lval);
                    idx_next = idx_reg + 1'b1;
                    raddr = AW'(idx_reg + 1'b1);
                end
            end
            S_PRD:
            begin
                ax_next = xrd_reg;
                ay_next = yrd_reg;
                raddr = AW'(cnt_reg);
                st_next = S_PA;
            end
            S_PA:
            begin
                raddr = AW'(cnt_reg);
                st_next = S_PB;
            end
            S_PB:
            begin
                dx_next = 17'(xrd_reg) - 17'(ax_reg);
                dy_next = 17'(yrd_reg) - 17'(ay_reg);
                st_next = S_CWAIT;
                cnt_next = '0;
                idx_next = cnt_reg;
            end
            S_CWAIT:
            begin
                if (cnt_reg == '0)
                begin
                    crd_start = 1'b1;
                    cnt_next = NW'(1);
                end
                else if (crd_done)
                begin
                    head_next = crd_head;
                    seg_next = 6'(idx_reg);
                    st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    oh_next = head_reg;
                    orun_next = run_reg;
                    olat_next = latch_reg;
                    oseg_next = seg_reg;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ppg_reg <= 16'd100;
            nuse_reg <= '0;
            fill_reg <= '0;
            run_reg <= 1'b0;
            latch_reg <= 1'b0;
            mile_reg <= '0;
            prev_reg <= '0;
            head_reg <= '0;
            seg_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
                ppg_reg <= cfg_wdata;
            nuse_reg <= nuse_next;
            fill_reg <= fill_next;
            run_reg <= run_next;
            latch_reg <= latch_next;
            mile_reg <= mile_next;
            prev_reg <= prev_next;
            head_reg <= head_next;
            seg_reg <= seg_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        d2_reg <= d2_next;
        q_reg <= q_next;
        r_reg <= r_next;
        k_reg <= k_next;
        acc_reg <= acc_next;
        tot_reg <= tot_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        oh_reg <= oh_next;
        orun_reg <= orun_next;
        olat_reg <= olat_next;
        oseg_reg <= oseg_next;
    end

    assign out_valid = ovalid_reg;
    assign target_heading = oh_reg;
    assign is_running = orun_reg;
    assign stop_latched = olat_reg;
    assign current_segment = oseg_reg;
endmodule
`default_nettype wire
